// File: rtl/tiled_texture_to_rgba_decoder_assert.svh
// Assertion macros used by the decoder back end.
`ifndef TILED_TEXTURE_TO_RGBA_DECODER_ASSERT_SVH
`define TILED_TEXTURE_TO_RGBA_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define TTD_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TTD_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TTD_ASSERT_IMP(label, clk, rstn, ante, cons)
`define TTD_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/ttd_pkg.sv
// Types, constants and channel-widening functions of the tiled texture decoder.
package ttd_pkg;
  localparam int MAX_DIM = 1024;
  localparam int CW = 11;

  typedef enum logic [2:0] {
    FMT_I4, FMT_I8, FMT_IA4, FMT_IA8, FMT_RGB565, FMT_RGB5A3, FMT_RGBA8, FMT_CMPR
  } fmt_e;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef enum logic [1:0] {
    JOB_NONE, JOB_ONE, JOB_TWO, JOB_FOUR
  } job_e;

  typedef struct packed {
    logic [3:0][7:0] red;
    logic [3:0][7:0] green;
    logic [3:0][7:0] blue;
    logic [3:0][7:0] alpha;
    logic [3:0]      keep;
    logic [12:0]     x;
    logic [12:0]     y;
    logic            img_end;
  } job_t;

  typedef struct packed {
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       run_last;
    logic       image_last;
  } pix_t;

  function automatic logic [7:0] w3(input logic [2:0] v);
    return 8'((23'(v) * 23'd596955) >> 14);
  endfunction
  function automatic logic [7:0] w4(input logic [3:0] v);
    return 8'({4'b0, v} * 8'd17);
  endfunction
  function automatic logic [7:0] w5(input logic [4:0] v);
    return 8'((27'(v) * 27'd2156535) >> 18);
  endfunction
  function automatic logic [7:0] w6(input logic [5:0] v);
    return 8'((29'(v) * 29'd4244475) >> 20);
  endfunction
  function automatic logic [7:0] d3(input logic [9:0] v);
    return 8'((21'(v) * 21'd1366) >> 12);
  endfunction
endpackage

// File: rtl/ttd_if.sv
// Valid-ready channel carrying one payload word.
interface ttd_if #(parameter int W = 8) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/ttd_front.sv
// Front end: tracks tile position, decodes a byte into up to four pixels.
module ttd_front import ttd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  ttd_if.sink           in_if,
  ttd_if.sink           cfg_if,
  output logic          push_o,
  output job_t          job_o,
  output logic [CW-1:0] wid_o,
  output logic [CW-1:0] hgt_o,
  input  logic          full_i
);
  logic [2:0]    fmt_q;
  logic [CW-1:0] wid_q, hgt_q;
  logic [8:0]    tcol_q, trow_q;
  logic [5:0]    bit_q;
  logic [7:0]    held_q;
  logic [15:0]   ar_q [16];
  logic [15:0]   e0_q, e1_q;
  logic [23:0]   c0_q, c1_q;
  logic          acc;
  logic [7:0]    d;
  logic [CW-1:0] cdim;
  logic [3:0]    tw, th;
  logic [8:0]    tx_n, ty_n;
  logic [12:0]   bx, by;
  logic          tile_end;
  logic [3:0]    p;
  logic [15:0]   v;
  logic [7:0]    pr[4], pg[4], pb[4], pa[4];
  logic [9:0]    s2r, s2g, s2b;
  logic [1:0]    idx;
  job_t          j;

  assign acc = in_if.valid && in_if.ready;
  assign in_if.ready = !full_i;
  assign cfg_if.ready = 1'b1;
  assign d = in_if.data;
  assign wid_o = wid_q;
  assign hgt_o = hgt_q;

  always_comb begin
    cdim = cfg_if.data[CW-1:0];
    if (cdim == '0) cdim = CW'(1);
    if (cdim > CW'(MAX_DIM)) cdim = CW'(MAX_DIM);
  end

  always_comb begin
    tw = (fmt_q == FMT_I4 || fmt_q == FMT_I8 || fmt_q == FMT_IA4 || fmt_q == FMT_CMPR)
         ? 4'd8 : 4'd4;
    th = (fmt_q == FMT_I4 || fmt_q == FMT_CMPR) ? 4'd8 : 4'd4;
    tx_n = (tw == 4'd8) ? 9'((wid_q + CW'(7)) >> 3) : 9'((wid_q + CW'(3)) >> 2);
    ty_n = (th == 4'd8) ? 9'((hgt_q + CW'(7)) >> 3) : 9'((hgt_q + CW'(3)) >> 2);
    bx = (tw == 4'd8) ? {1'b0, tcol_q, 3'b0} : {2'b0, tcol_q, 2'b0};
    by = (th == 4'd8) ? {1'b0, trow_q, 3'b0} : {2'b0, trow_q, 2'b0};
    tile_end = (fmt_q == FMT_RGBA8) ? (bit_q == 6'd63) : (bit_q[4:0] == 5'd31);
    v = {held_q, d};
    p = bit_q[4:1];
  end

  always_comb begin
    pr[0] = c0_q[23:16]; pg[0] = c0_q[15:8]; pb[0] = c0_q[7:0];
    pr[1] = c1_q[23:16]; pg[1] = c1_q[15:8]; pb[1] = c1_q[7:0];
    pa[0] = 8'd255; pa[1] = 8'd255; pa[2] = 8'd255;
    s2r = 10'(pr[0]) + 10'(pr[1]);
    s2g = 10'(pg[0]) + 10'(pg[1]);
    s2b = 10'(pb[0]) + 10'(pb[1]);
    if (e0_q > e1_q) begin
      pr[2] = d3(10'(pr[0]) + s2r);
      pg[2] = d3(10'(pg[0]) + s2g);
      pb[2] = d3(10'(pb[0]) + s2b);
      pr[3] = d3(10'(pr[1]) + s2r);
      pg[3] = d3(10'(pg[1]) + s2g);
      pb[3] = d3(10'(pb[1]) + s2b);
      pa[3] = 8'd255;
    end else begin
      pr[2] = s2r[8:1]; pg[2] = s2g[8:1]; pb[2] = s2b[8:1];
      pr[3] = '0; pg[3] = '0; pb[3] = '0; pa[3] = '0;
    end
  end

  always_comb begin
    j = '0;
    idx = '0;
    j.x = bx;
    j.y = by;
    case (fmt_q)
      FMT_I4: begin
        j.x = bx + 13'({bit_q[1:0], 1'b0});
        j.y = by + 13'(bit_q[5:2]);
        j.red[0] = w4(d[7:4]); j.red[1] = w4(d[3:0]);
        j.green = j.red; j.blue = j.red;
        j.alpha[0] = 8'd255; j.alpha[1] = 8'd255;
        j.keep = 4'b0011;
      end
      FMT_I8, FMT_IA4: begin
        j.x = bx + 13'(bit_q[2:0]);
        j.y = by + 13'(bit_q[5:3]);
        j.red[0] = (fmt_q == FMT_I8) ? d : w4(d[3:0]);
        j.green[0] = j.red[0]; j.blue[0] = j.red[0];
        j.alpha[0] = (fmt_q == FMT_I8) ? 8'd255 : w4(d[7:4]);
        j.keep = 4'b0001;
      end
      FMT_IA8, FMT_RGB565, FMT_RGB5A3, FMT_RGBA8: begin
        j.x = bx + 13'(p[1:0]);
        j.y = by + 13'(p[3:2]);
        j.keep = {3'b0, bit_q[0] && (fmt_q != FMT_RGBA8 || bit_q[5])};
        if (fmt_q == FMT_IA8) begin
          j.red[0] = d; j.green[0] = d; j.blue[0] = d; j.alpha[0] = held_q;
        end else if (fmt_q == FMT_RGB565) begin
          j.red[0] = w5(v[15:11]); j.green[0] = w6(v[10:5]);
          j.blue[0] = w5(v[4:0]); j.alpha[0] = 8'd255;
        end else if (fmt_q == FMT_RGB5A3) begin
          if (v[15]) begin
            j.red[0] = w5(v[14:10]); j.green[0] = w5(v[9:5]);
            j.blue[0] = w5(v[4:0]); j.alpha[0] = 8'd255;
          end else begin
            j.alpha[0] = w3(v[14:12]); j.red[0] = w4(v[11:8]);
            j.green[0] = w4(v[7:4]); j.blue[0] = w4(v[3:0]);
          end
        end else begin
          j.red[0] = ar_q[p][7:0]; j.green[0] = held_q;
          j.blue[0] = d; j.alpha[0] = ar_q[p][15:8];
        end
      end
      default: begin
        j.x = bx + 13'({bit_q[3], 2'b0});
        j.y = by + 13'({bit_q[4], 2'b0}) + 13'(bit_q[1:0]);
        j.keep = {4{bit_q[2]}};
        for (int c = 0; c < 4; c++) begin
          idx = d[7-2*c -: 2];
          j.red[c] = pr[idx]; j.green[c] = pg[idx];
          j.blue[c] = pb[idx]; j.alpha[c] = pa[idx];
        end
      end
    endcase
    j.img_end = tile_end && (tcol_q + 9'd1 >= tx_n) && (trow_q + 9'd1 >= ty_n);
  end

  assign push_o = acc;
  assign job_o = j;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_I4;
      wid_q <= CW'(MAX_DIM);
      hgt_q <= CW'(MAX_DIM);
      tcol_q <= '0;
      trow_q <= '0;
      bit_q <= '0;
      held_q <= '0;
    end else if (cfg_if.valid
                 && (cfg_if.data[CW+1:CW] inside {REG_FORMAT, REG_WIDTH, REG_HEIGHT})) begin
      case (cfg_if.data[CW+1:CW])
        REG_FORMAT: fmt_q <= cfg_if.data[2:0];
        REG_WIDTH: wid_q <= cdim;
        default: hgt_q <= cdim;
      endcase
      tcol_q <= '0;
      trow_q <= '0;
      bit_q <= '0;
    end else if (acc) begin
      if (!bit_q[0] || (fmt_q == FMT_CMPR && bit_q[2:0] == 3'd2)) held_q <= d;
      if (tile_end) begin
        bit_q <= '0;
        if (tcol_q + 9'd1 >= tx_n) begin
          tcol_q <= '0;
          trow_q <= (trow_q + 9'd1 >= ty_n) ? 9'd0 : trow_q + 9'd1;
        end else begin
          tcol_q <= tcol_q + 9'd1;
        end
      end else begin
        bit_q <= bit_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && fmt_q == FMT_RGBA8 && bit_q[0] && !bit_q[5]) ar_q[p] <= v;
    if (acc && fmt_q == FMT_CMPR && bit_q[2:0] == 3'd1) begin
      e0_q <= v;
      c0_q <= {w5(v[15:11]), w6(v[10:5]), w5(v[4:0])};
    end
    if (acc && fmt_q == FMT_CMPR && bit_q[2:0] == 3'd3) begin
      e1_q <= v;
      c1_q <= {w5(v[15:11]), w6(v[10:5]), w5(v[4:0])};
    end
  end
endmodule

// File: rtl/ttd_back.sv
// Back end: job queue and serializer emitting one visible pixel per cycle while the receiver is ready.
module ttd_back import ttd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  job_t  job_i,
  output logic  full_o,
  input  logic [CW-1:0] wid_i,
  input  logic [CW-1:0] hgt_i,
  ttd_if.source out_if
);
  `include "tiled_texture_to_rgba_decoder_assert.svh"
  job_t       q_q [2];
  logic [1:0] cnt_q;
  logic       wp_q, rp_q;
  logic [3:0] left_q;
  job_t       h;
  logic [3:0] vis;
  logic [1:0] sel;
  logic [3:0] rest;
  logic       pop, fire, done;
  pix_t       o_q;
  logic       ov_q;

  assign h = q_q[rp_q];
  assign full_o = cnt_q == 2'd2;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      vis[c] = h.keep[c] && left_q[c] && (h.x + 13'(c) < 13'(wid_i))
               && (h.y < 13'(hgt_i));
    end
    sel = vis[0] ? 2'd0 : vis[1] ? 2'd1 : vis[2] ? 2'd2 : 2'd3;
    rest = vis & ~(4'b1 << sel);
    fire = cnt_q != 2'd0 && vis != 4'd0 && (!ov_q || out_if.ready);
    done = cnt_q != 2'd0 && (vis == 4'd0 || (fire && rest == 4'd0));
    pop = done;
  end

  assign out_if.valid = ov_q;
  assign out_if.data = o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; wp_q <= 1'b0; rp_q <= 1'b0; left_q <= 4'hF; ov_q <= 1'b0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
      if (pop) left_q <= 4'hF;
      else if (fire) left_q <= left_q & ~(4'b1 << sel);
      if (fire) ov_q <= 1'b1;
      else if (out_if.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) q_q[wp_q] <= job_i;
    if (fire) begin
      o_q.pixel_x <= 10'(h.x + 13'(sel));
      o_q.pixel_y <= 10'(h.y);
      o_q.red <= h.red[sel];
      o_q.green <= h.green[sel];
      o_q.blue <= h.blue[sel];
      o_q.alpha <= h.alpha[sel];
      o_q.run_last <= rest == 4'd0;
      o_q.image_last <= h.img_end;
    end
  end

  `TTD_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push_i, cnt_q != 2'd2 || pop)
  `TTD_ASSERT_NXT(a_hold, clk_i, rst_ni, ov_q && !out_if.ready, ov_q)
  `TTD_ASSERT_IMP(a_cnt, clk_i, rst_ni, 1'b1, cnt_q != 2'd3)
endmodule

// File: rtl/tiled_texture_to_rgba_decoder.sv
// Top level of the tiled texture to RGBA8 decoder.
// Channels: in_if carries one texture byte per word; cfg_if writes a
// register, with the index in the top two data bits above an 11-bit value
// (0 format, 1 width, 2 height); out_if carries one RGBA8 pixel per word
// with its coordinates and the run and image end flags.
// A byte is decoded in the cycle it is accepted and queued in a two-entry
// job queue; the back end then emits one pixel per cycle, while the
// receiver is ready, from the queue head into an output register.
// I4 bytes give two pixels and CMPR index bytes four; other formats give at
// most one pixel per byte, and pixels outside the image are skipped.
// Reset selects I4 at 1024 by 1024 and the first tile. A configuration
// write restarts the image. When the receiver stalls, the output register
// holds, the queue fills and then the input side is held off.
module tiled_texture_to_rgba_decoder import ttd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  ttd_if.sink  in_if,
  ttd_if.sink  cfg_if,
  ttd_if.source out_if
);
  logic push, full;
  job_t job;
  logic [CW-1:0] wid, hgt;

  ttd_front u_front (
    .clk_i, .rst_ni, .in_if, .cfg_if, .push_o(push), .job_o(job),
    .wid_o(wid), .hgt_o(hgt), .full_i(full)
  );

  ttd_back u_back (
    .clk_i, .rst_ni, .push_i(push), .job_i(job), .full_o(full),
    .wid_i(wid), .hgt_i(hgt), .out_if
  );
endmodule
